@@ design/ors_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ors_pkg: shared types and constants of the 1-Wire search-ROM engine
// Beat formats of both channels, command codes and the sequencer states.
// ----------------------------------------------------------------------------
package ors_pkg;

    localparam int POS_W = 6;
    localparam int ROM_W = 64;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_PAIR  = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [POS_W-1:0] start_split;
        logic             id_bit;
        logic             complement_bit;
    } item_beat_t;

    typedef struct packed {
        logic             write_bit;
        logic             last;
        logic             no_device;
        logic [POS_W-1:0] next_split;
        logic [ROM_W-1:0] rom_id;
    } result_beat_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } seq_state_t;

endpackage
`default_nettype wire

@@ design/onewire_rom_search_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// onewire_rom_search_top: 1-Wire search-ROM engine
// Answers each read bit pair with the direction bit, tracks the ROM code and
// the split point, and reports the ROM and next split after the last bit.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake                    Beat type
//  item     in   item_valid / item_ready      ors_pkg::item_beat_t
//  result   out  result_valid / result_ready  ors_pkg::result_beat_t
//
//  A begin gives no result; a pair of two 1 bits aborts with no_device set.
//  The last bit pair waits for the split relocation, which walks down
//  the confirmed bits one position a cycle in ors_split_scan.
//  The result sits in an output register; a new item is taken while it drains.
//  Reset clears the ROM, confirmed bits, position and split; no search runs.
// ----------------------------------------------------------------------------
module onewire_rom_search_top #(
    parameter int ROM_BITS = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire ors_pkg::item_beat_t   item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output ors_pkg::result_beat_t      result
);

    localparam int IDX_W = (ROM_BITS > 1) ? $clog2(ROM_BITS) : 1;
    localparam logic [ors_pkg::POS_W-1:0] LastPos = ors_pkg::POS_W'(ROM_BITS - 1);

    ors_pkg::seq_state_t state_reg, state_next;

    logic [ROM_BITS-1:0]       rom_reg, rom_next;
    logic [ROM_BITS-1:0]       conf_reg, conf_next;
    logic [ors_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [ors_pkg::POS_W-1:0] split_reg, split_next;
    logic                      none_reg, none_next;
    logic                      active_reg, active_next;
    logic                      wb_reg, wb_next;

    logic                      out_valid_reg, out_valid_next;
    ors_pkg::result_beat_t     out_reg, out_next;

    logic                      accept;
    logic                      out_free;
    logic                      final_pair;
    logic                      scan_start;
    logic                      scan_take;
    logic                      scan_done;
    logic [ors_pkg::POS_W-1:0] scan_split;
    logic [ors_pkg::POS_W-1:0] scan_from;
    logic [IDX_W-1:0]          idx;
    logic [ors_pkg::ROM_W-1:0] rom_ext;

    assign out_free     = !out_valid_reg || result_ready;
    assign accept       = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign idx          = pos_reg[IDX_W-1:0];

    always_comb
    begin
        rom_ext = '0;
        rom_ext[ROM_BITS-1:0] = rom_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ors_pkg::ST_IDLE:
            begin
                if (final_pair)
                begin
                    state_next = ors_pkg::ST_SCAN;
                end
            end
            ors_pkg::ST_SCAN:
            begin
                if (scan_done && out_free)
                begin
                    state_next = ors_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ors_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        item_ready = 1'b0;
        scan_take  = 1'b0;
        unique case (state_reg)
            ors_pkg::ST_IDLE:
            begin
                item_ready = out_free;
            end
            ors_pkg::ST_SCAN:
            begin
                scan_take = scan_done && out_free;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // per-bit datapath
    always_comb
    begin
        rom_next       = rom_reg;
        conf_next      = conf_reg;
        pos_next       = pos_reg;
        split_next     = split_reg;
        none_next      = none_reg;
        active_next    = active_reg;
        wb_next        = wb_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        final_pair     = 1'b0;

        if (accept && (item.cmd == ors_pkg::CMD_BEGIN))
        begin
            split_next  = item.start_split;
            none_next   = (item.start_split == '0);
            pos_next    = '0;
            active_next = 1'b1;
        end
        else if (accept && active_reg)
        begin
            if (item.id_bit && item.complement_bit)
            begin
                // abort: nobody answered
                active_next        = 1'b0;
                out_valid_next     = 1'b1;
                out_next.write_bit = 1'b0;
                out_next.last      = 1'b1;
                out_next.no_device = 1'b1;
                out_next.next_split = '0;
                out_next.rom_id    = '0;
            end
            else
            begin
                if (item.id_bit)
                begin
                    rom_next[idx]  = 1'b1;
                    conf_next[idx] = 1'b1;
                    wb_next        = 1'b1;
                end
                else if (item.complement_bit)
                begin
                    rom_next[idx]  = 1'b0;
                    conf_next[idx] = 1'b1;
                    wb_next        = 1'b0;
                end
                else if (none_reg || (pos_reg > split_reg))
                begin
                    // new discrepancy: try the zero branch first
                    rom_next[idx]  = 1'b0;
                    conf_next[idx] = 1'b0;
                    split_next     = pos_reg;
                    none_next      = 1'b0;
                    wb_next        = 1'b0;
                end
                else if (pos_reg == split_reg)
                begin
                    rom_next[idx]  = 1'b1;
                    conf_next[idx] = 1'b1;
                    wb_next        = 1'b1;
                end
                else
                begin
                    wb_next = rom_reg[idx];
                end

                if (pos_reg == LastPos)
                begin
                    // hold the answer until the relocation settles
                    active_next = 1'b0;
                    final_pair  = 1'b1;
                end
                else
                begin
                    pos_next            = pos_reg + 1'b1;
                    out_valid_next      = 1'b1;
                    out_next.write_bit  = wb_next;
                    out_next.last       = 1'b0;
                    out_next.no_device  = 1'b0;
                    out_next.next_split = '0;
                    out_next.rom_id     = '0;
                end
            end
        end

        if (scan_take)
        begin
            out_valid_next      = 1'b1;
            out_next.write_bit  = wb_reg;
            out_next.last       = 1'b1;
            out_next.no_device  = 1'b0;
            out_next.next_split = scan_split;
            out_next.rom_id     = rom_ext;
        end
    end

    assign scan_start = final_pair;
    assign scan_from  = none_next ? '0 : split_next;

    ors_split_scan #(
        .ROM_BITS (ROM_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .start_pos (scan_from),
        .confirmed (conf_reg),
        .take      (scan_take),
        .done      (scan_done),
        .split     (scan_split)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ors_pkg::ST_IDLE;
            rom_reg       <= '0;
            conf_reg      <= '0;
            pos_reg       <= '0;
            split_reg     <= '0;
            none_reg      <= 1'b1;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rom_reg       <= rom_next;
            conf_reg      <= conf_next;
            pos_reg       <= pos_next;
            split_reg     <= split_next;
            none_reg      <= none_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wb_reg  <= wb_next;
        out_reg <= out_next;
    end

endmodule
`default_nettype wire

@@ design/ors_split_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ors_split_scan: split relocation unit
// Walks down from the split point, one position a cycle, to the highest
// unconfirmed position or to zero. Holds the answer until it is taken.
// ----------------------------------------------------------------------------
module ors_split_scan #(
    parameter int ROM_BITS = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [ors_pkg::POS_W-1:0] start_pos,
    input  wire logic [ROM_BITS-1:0]       confirmed,
    input  wire logic                      take,
    output logic                           done,
    output logic [ors_pkg::POS_W-1:0]      split
);

    localparam int IDX_W = (ROM_BITS > 1) ? $clog2(ROM_BITS) : 1;
    localparam logic [ors_pkg::POS_W:0] RomLimit = (ors_pkg::POS_W + 1)'(ROM_BITS);

    logic                      busy_reg, busy_next;
    logic [ors_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      in_range;
    logic                      hit;

    always_comb
    begin
        in_range = ({1'b0, pos_reg} < RomLimit);
        // stop at zero, past the stored range, or on an unconfirmed position
        hit = (pos_reg == '0) || !in_range || !confirmed[pos_reg[IDX_W-1:0]];
    end

    assign done  = busy_reg && hit;
    assign split = pos_reg;

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pos_next  = start_pos;
        end
        else if (busy_reg)
        begin
            if (!hit)
            begin
                pos_next = pos_reg - 1'b1;
            end
            else if (take)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

endmodule
`default_nettype wire

@@ sim/tb_onewire_rom_search_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_onewire_rom_search_top: self-checking bench of the 1-Wire search engine
// Drives begin beats and read bit pairs through the item channel, predicts
// each direction bit, final ROM and next split, and checks every result beat
// in order. A short directed table opens the run, then whole searches follow
// with random bus answers, aborts, cut-off searches and stray pairs.
// ----------------------------------------------------------------------------
module tb_onewire_rom_search_top;

    localparam int ROM_BITS     = 64;
    localparam int DIR_ROWS     = 24;
    localparam int RAND_ITEMS   = 1625;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = ROM_BITS + 16;

    typedef struct packed {
        ors_pkg::item_beat_t   beat;
        logic                  has_lit;
        ors_pkg::result_beat_t lit;
    } stim_row_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_pattern_t;

    typedef enum logic [1:0] {
        SRCH_CLEAN,
        SRCH_SPLIT_AT_ZERO,
        SRCH_MIXED
    } search_mode_t;

    localparam ors_pkg::result_beat_t RES_ABORT  = '{1'b0, 1'b1, 1'b1, 6'd0, 64'd0};
    localparam ors_pkg::result_beat_t RES_WROTE1 = '{1'b1, 1'b0, 1'b0, 6'd0, 64'd0};
    localparam ors_pkg::result_beat_t RES_WROTE0 = '{1'b0, 1'b0, 1'b0, 6'd0, 64'd0};
    localparam ors_pkg::result_beat_t RES_NONE   = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    ors_pkg::item_beat_t   item;
    logic                  result_valid;
    logic                  result_ready;
    ors_pkg::result_beat_t result;

    onewire_rom_search_top #(
        .ROM_BITS(ROM_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // search state mirrored by the predictor
    logic [ROM_BITS-1:0]       rom_kept;
    logic [ROM_BITS-1:0]       rom_confirmed;
    logic [ors_pkg::POS_W-1:0] scan_pos;
    logic [ors_pkg::POS_W-1:0] split_pos;
    logic                      split_unset;
    logic                      search_on;

    ors_pkg::result_beat_t expected_q[$];
    stim_row_t             lit_q[$];
    stim_row_t             dir_tab [DIR_ROWS];

    int           n_errors;
    int           n_checked;
    int           n_accepted;
    int           n_done;
    int           n_aborts;
    int           n_holds;
    int           burst_left;
    logic [ors_pkg::POS_W-1:0] last_next_split;
    bit           hold_req;

    ors_pkg::result_beat_t mon_pred;
    stim_row_t             mon_row;
    ors_pkg::result_beat_t mon_want;

    function automatic ors_pkg::item_beat_t mk_beat(input logic c,
                                                    input logic [ors_pkg::POS_W-1:0] sp,
                                                    input logic id, input logic cb);
        ors_pkg::item_beat_t b;
        b.cmd            = c;
        b.start_split    = sp;
        b.id_bit         = id;
        b.complement_bit = cb;
        return b;
    endfunction

    // Advance the search by one beat; return 1 when a result beat is due.
    function automatic bit step_search(input ors_pkg::item_beat_t b,
                                       output ors_pkg::result_beat_t r);
        logic [ors_pkg::POS_W-1:0] p;
        logic [ors_pkg::POS_W-1:0] q;
        logic [ROM_BITS-1:0]       m;
        logic                      wb;
        r = '0;
        if (b.cmd == ors_pkg::CMD_BEGIN)
        begin
            split_pos   = b.start_split;
            split_unset = (b.start_split == 0);
            scan_pos    = '0;
            search_on   = 1'b1;
            return 1'b0;
        end
        if (!search_on)
            return 1'b0;
        p = scan_pos;
        m = {{(ROM_BITS-1){1'b0}}, 1'b1} << p;
        if (b.id_bit && b.complement_bit)
        begin
            search_on   = 1'b0;
            r.last      = 1'b1;
            r.no_device = 1'b1;
            return 1'b1;
        end
        if (b.id_bit)
        begin
            rom_kept      |= m;
            rom_confirmed |= m;
            wb = 1'b1;
        end
        else if (b.complement_bit)
        begin
            rom_kept      &= ~m;
            rom_confirmed |= m;
            wb = 1'b0;
        end
        else if (split_unset || p > split_pos)
        begin
            // discrepancy past the old split: try 0 and remember it
            rom_kept      &= ~m;
            rom_confirmed &= ~m;
            split_pos   = p;
            split_unset = 1'b0;
            wb = 1'b0;
        end
        else if (p == split_pos)
        begin
            rom_kept      |= m;
            rom_confirmed |= m;
            wb = 1'b1;
        end
        else
            wb = rom_kept[p];
        r.write_bit = wb;
        if (p == ors_pkg::POS_W'(ROM_BITS - 1))
        begin
            search_on = 1'b0;
            r.last    = 1'b1;
            r.rom_id  = rom_kept;
            q = '0;
            if (!split_unset)
            begin
                // walk down to the highest open branch
                q = split_pos;
                while (q > 0 && rom_confirmed[q])
                    q--;
            end
            r.next_split = q;
        end
        else
            scan_pos = p + 1'b1;
        return 1'b1;
    endfunction

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", fname, want, got);
            n_errors++;
        end
    endtask

    // Check result beats first, then predict for the item beat taken at this edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with nothing expected: %h", result);
                    n_errors++;
                end
                else
                begin
                    mon_want = expected_q.pop_front();
                    check_field("write_bit", 64'(mon_want.write_bit),
                                64'(result.write_bit));
                    check_field("last", 64'(mon_want.last), 64'(result.last));
                    check_field("no_device", 64'(mon_want.no_device),
                                64'(result.no_device));
                    check_field("next_split", 64'(mon_want.next_split),
                                64'(result.next_split));
                    check_field("rom_id", mon_want.rom_id, result.rom_id);
                    n_checked++;
                end
            end
            if (item_valid && item_ready)
            begin
                mon_row = lit_q.pop_front();
                n_accepted++;
                if (step_search(item, mon_pred))
                begin
                    if (mon_pred.last)
                    begin
                        if (mon_pred.no_device)
                            n_aborts++;
                        else
                            n_done++;
                        last_next_split = mon_pred.next_split;
                    end
                    expected_q.push_back(mon_row.has_lit ? mon_row.lit : mon_pred);
                end
            end
        end
    end

    task automatic send_beat(input ors_pkg::item_beat_t b, input logic has_lit,
                             input ors_pkg::result_beat_t lit);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        lit_q.push_back('{b, has_lit, lit});
        item_valid <= 1'b1;
        item       <= b;
        @(posedge clk);
        while (!(item_valid && item_ready))
            @(posedge clk);
        burst_left--;
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: shifting stall patterns, plus one long hold-off on request.
    initial
    begin
        rx_pattern_t rx_mode;
        int          rx_left;
        rx_mode = RX_FREE;
        rx_left = 0;
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                n_holds++;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = rx_pattern_t'($urandom_range(0, 3));
                    rx_left = $urandom_range(16, 96);
                end
                rx_left--;
                case (rx_mode)
                    RX_FREE:  result_ready <= 1'b1;
                    RX_LIGHT: result_ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: result_ready <= ($urandom_range(0, 3) == 0);
                    default:  result_ready <= ((rx_left % 3) != 0);
                endcase
            end
        end
    end

    initial
    begin
        #5ms;
        $display("** onewire_rom_search_top: FAILED **");
        $finish;
    end

    initial
    begin
        search_mode_t              mode;
        int                        n_sent;
        int                        n_search;
        int                        rate;
        int                        abort_at;
        int                        cut_at;
        int                        pos;
        logic                      disc;
        logic                      id;
        logic [ors_pkg::POS_W-1:0] sp;

        rom_kept        = '0;
        rom_confirmed   = '0;
        scan_pos        = '0;
        split_pos       = '0;
        split_unset     = 1'b1;
        search_on       = 1'b0;
        n_errors        = 0;
        n_checked       = 0;
        n_accepted      = 0;
        n_done          = 0;
        n_aborts        = 0;
        n_holds         = 0;
        burst_left      = 0;
        last_next_split = '0;
        hold_req        = 1'b0;
        n_sent          = 0;
        n_search        = 0;

        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;

        dir_tab = '{
            // pairs with no search running are dropped
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd0,  1'b1, 1'b0), 1'b0, RES_NONE},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd0,  1'b1, 1'b1), 1'b0, RES_NONE},
            // empty bus aborts at once, then the engine is idle again
            '{mk_beat(ors_pkg::CMD_BEGIN, 6'd0,  1'b0, 1'b0), 1'b0, RES_NONE},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd0,  1'b1, 1'b1), 1'b1, RES_ABORT},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd0,  1'b0, 1'b1), 1'b0, RES_NONE},
            // highest split: discrepancies below it repeat the kept bit
            '{mk_beat(ors_pkg::CMD_BEGIN, 6'd63, 1'b1, 1'b1), 1'b0, RES_NONE},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd0,  1'b0, 1'b0), 1'b0, RES_NONE},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd0,  1'b1, 1'b0), 1'b1, RES_WROTE1},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd0,  1'b0, 1'b1), 1'b1, RES_WROTE0},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd63, 1'b0, 1'b0), 1'b0, RES_NONE},
            // below, at and above the split
            '{mk_beat(ors_pkg::CMD_BEGIN, 6'd2,  1'b0, 1'b0), 1'b0, RES_NONE},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd0,  1'b0, 1'b1), 1'b1, RES_WROTE0},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd0,  1'b0, 1'b0), 1'b0, RES_NONE},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd0,  1'b0, 1'b0), 1'b0, RES_NONE},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd0,  1'b0, 1'b0), 1'b0, RES_NONE},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd21, 1'b1, 1'b1), 1'b1, RES_ABORT},
            // no earlier split: first discrepancy lands at position zero
            '{mk_beat(ors_pkg::CMD_BEGIN, 6'd0,  1'b1, 1'b0), 1'b0, RES_NONE},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd0,  1'b0, 1'b0), 1'b0, RES_NONE},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd42, 1'b0, 1'b0), 1'b0, RES_NONE},
            // begin in the middle of a search restarts it
            '{mk_beat(ors_pkg::CMD_BEGIN, 6'd5,  1'b0, 1'b1), 1'b0, RES_NONE},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd0,  1'b1, 1'b0), 1'b1, RES_WROTE1},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd0,  1'b1, 1'b1), 1'b1, RES_ABORT},
            '{mk_beat(ors_pkg::CMD_BEGIN, 6'd31, 1'b0, 1'b0), 1'b0, RES_NONE},
            '{mk_beat(ors_pkg::CMD_PAIR,  6'd0,  1'b0, 1'b0), 1'b0, RES_NONE}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(dir_tab[i].beat, dir_tab[i].has_lit, dir_tab[i].lit);

        while (n_sent < RAND_ITEMS)
        begin
            // mostly chain the split from the finished search, as a host would
            if ($urandom_range(0, 2) != 0)
            begin
                drain_results();
                sp = last_next_split;
            end
            else
                sp = ($urandom_range(0, 7) == 0) ? '0 :
                     ors_pkg::POS_W'($urandom_range(0, 63));
            send_beat(mk_beat(ors_pkg::CMD_BEGIN, sp, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1))), 1'b0, RES_NONE);
            n_sent++;
            n_search++;

            case ($urandom_range(0, 9))
                0:       mode = SRCH_CLEAN;
                1:       mode = SRCH_SPLIT_AT_ZERO;
                default: mode = SRCH_MIXED;
            endcase
            rate     = $urandom_range(1, 25);
            abort_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : ROM_BITS;
            cut_at   = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 63) : ROM_BITS;

            // one long receiver hold-off while a full search streams in
            if (n_search == 4)
            begin
                hold_req = 1'b1;
                abort_at = ROM_BITS;
                cut_at   = ROM_BITS;
            end

            for (pos = 0; pos < ROM_BITS && pos < cut_at; pos++)
            begin
                sp = ors_pkg::POS_W'($urandom_range(0, 63));
                if (pos == abort_at)
                begin
                    send_beat(mk_beat(ors_pkg::CMD_PAIR, sp, 1'b1, 1'b1), 1'b0, RES_NONE);
                    n_sent++;
                    break;
                end
                case (mode)
                    SRCH_CLEAN:         disc = 1'b0;
                    SRCH_SPLIT_AT_ZERO: disc = (pos == 0);
                    default:            disc = ($urandom_range(0, 99) < rate);
                endcase
                id = 1'($urandom_range(0, 1));
                if (disc)
                    send_beat(mk_beat(ors_pkg::CMD_PAIR, sp, 1'b0, 1'b0), 1'b0, RES_NONE);
                else
                    send_beat(mk_beat(ors_pkg::CMD_PAIR, sp, id, !id), 1'b0, RES_NONE);
                n_sent++;
            end

            // stray pairs between searches
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3))
                    send_beat(mk_beat(ors_pkg::CMD_PAIR,
                                      ors_pkg::POS_W'($urandom_range(0, 63)),
                                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                              1'b0, RES_NONE);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d item beats, %0d result beats checked, %0d searches",
                 n_accepted, n_checked, n_search);
        $display("  %0d ran to the last bit, %0d aborted on an empty bus, %0d long hold-offs.",
                 n_done, n_aborts, n_holds);
        if (n_errors == 0)
            $display("** onewire_rom_search_top: PASSED **");
        else
            $display("** onewire_rom_search_top: FAILED **");
        $finish;
    end

endmodule

@@ onewire_rom_search_top.f @@
design/ors_pkg.sv
design/ors_split_scan.sv
design/onewire_rom_search_top.sv
sim/tb_onewire_rom_search_top.sv
